// ===== hw/rtl/ismc_pkg.sv =====
// Package for the interval set membership counter.
// Holds sizes, codes, beat structs and the table request/response structs.
// No dependencies.
`default_nettype none

package ismc_pkg;

  localparam int MAX_INTERVALS = 256;
  localparam int VALUE_BITS    = 48;
  localparam int ADDR_W        = $clog2(MAX_INTERVALS);
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int HIT_W         = 32;
  localparam int STORED_W      = 9;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_INVERTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ismc_state_t;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] interval_start;
    logic [VALUE_BITS-1:0] interval_end;
    logic [VALUE_BITS-1:0] query_value;
  } ismc_in_t;

  typedef struct packed {
    status_t             status;
    logic                hit;
    logic [HIT_W-1:0]    hit_count;
    logic [STORED_W-1:0] stored_count;
  } ismc_out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
  } ismc_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              rd_last;
    logic [ADDR_W-1:0] addr;
    ismc_entry_t       wr_entry;
  } ismc_tbl_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic match;
  } ismc_tbl_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ismc_table.sv =====
// Interval table: one-port-write, one-port-read memory with registered read,
// followed by the range compare against the query value. Uses ismc_pkg.
`default_nettype none

module ismc_table
  import ismc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ismc_tbl_req_t         req,
  input  wire logic [VALUE_BITS-1:0] query_value,
  output ismc_tbl_rsp_t              rsp
);

  ismc_entry_t mem [MAX_INTERVALS];
  ismc_entry_t rd_q_r;
  logic        rd_valid_r;
  logic        rd_last_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_entry;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      rd_valid_r <= req.rd_en;
      rd_last_r  <= req.rd_en & req.rd_last;
    end
  end

  always_comb begin
    rsp.valid = rd_valid_r;
    rsp.last  = rd_last_r;
    rsp.match = rd_valid_r && (query_value >= rd_q_r.lo) && (query_value <= rd_q_r.hi);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/interval_set_membership_counter.sv =====
// Interval set membership counter: top level with control and output register.
// An add stores its interval unless full or inverted; a query reads each stored
// interval in S_SCAN, unless the table is empty. Both then load the output
// register from S_DONE. One item at a time: in_stall is high outside S_IDLE,
// and S_DONE waits while a stalled result still holds the output register.
// Reset clears the stored count and hit count; table contents stay undefined.
`default_nettype none

module interval_set_membership_counter
  import ismc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ismc_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ismc_out_t      out_data
);

  ismc_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [HIT_W-1:0]      hits_r, hits_nxt;
  logic                  acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] qv_r, qv_nxt;
  ismc_out_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ismc_out_t             out_data_r, out_data_nxt;

  ismc_tbl_req_t         req;
  ismc_tbl_rsp_t         rsp;
  logic                  in_acc;
  logic                  hit_fin;

  ismc_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .query_value (qv_r),
    .rsp         (rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    hits_nxt      = hits_r;
    acc_nxt       = acc_r;
    qv_nxt        = qv_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    req           = '0;
    hit_fin       = acc_r | rsp.match;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt.status = ST_OK;
          res_nxt.hit    = 1'b0;
          if (in_data.kind == KIND_ADD) begin
            if (cnt_r == CNT_W'(MAX_INTERVALS)) begin
              res_nxt.status = ST_FULL;
            end else if (in_data.interval_start > in_data.interval_end) begin
              res_nxt.status = ST_INVERTED;
            end else begin
              req.wr_en       = 1'b1;
              req.addr        = cnt_r[ADDR_W-1:0];
              req.wr_entry.lo = in_data.interval_start;
              req.wr_entry.hi = in_data.interval_end;
              cnt_nxt         = cnt_r + CNT_W'(1);
            end
            res_nxt.hit_count    = hits_r;
            res_nxt.stored_count = STORED_W'(cnt_nxt);
            state_nxt            = S_DONE;
          end else begin
            qv_nxt  = in_data.query_value;
            acc_nxt = 1'b0;
            if (cnt_r == '0) begin
              res_nxt.hit_count    = hits_r;
              res_nxt.stored_count = STORED_W'(cnt_r);
              state_nxt            = S_DONE;
            end else begin
              req.rd_en   = 1'b1;
              req.addr    = '0;
              req.rd_last = (cnt_r == CNT_W'(1));
              idx_nxt     = CNT_W'(1);
              state_nxt   = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (idx_r != cnt_r) begin
          req.rd_en   = 1'b1;
          req.addr    = idx_r[ADDR_W-1:0];
          req.rd_last = ((idx_r + CNT_W'(1)) == cnt_r);
          idx_nxt     = idx_r + CNT_W'(1);
        end
        if (rsp.valid) begin
          acc_nxt = hit_fin;
          if (rsp.last) begin
            if (hit_fin && (hits_r != '1)) begin
              hits_nxt = hits_r + HIT_W'(1);
            end
            res_nxt.status       = ST_OK;
            res_nxt.hit          = hit_fin;
            res_nxt.hit_count    = hits_nxt;
            res_nxt.stored_count = STORED_W'(cnt_r);
            state_nxt            = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    qv_r       <= qv_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== test/tb_interval_set_membership_counter.sv =====
`timescale 1ns / 1ps
// Self-checking bench for interval_set_membership_counter: random and directed
// add/query beats, an in-bench table model, and a scoreboard on the result port.
// Depends on ismc_pkg and the block's RTL.

module tb_interval_set_membership_counter;
  import ismc_pkg::*;

  localparam int unsigned N_RANDOM = 1700;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [VALUE_BITS-1:0] MAXV = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ismc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  ismc_out_t out_data;

  ismc_in_t feed[$];
  ismc_out_t pending_answers[$];
  logic [VALUE_BITS-1:0] gen_lo[$];
  logic [VALUE_BITS-1:0] gen_hi[$];

  logic [VALUE_BITS-1:0] tab_lo[MAX_INTERVALS];
  logic [VALUE_BITS-1:0] tab_hi[MAX_INTERVALS];
  int unsigned n_held = 0;
  logic [HIT_W-1:0] hit_tally = '0;

  int unsigned issued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_answered = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_no = 0;
  int unsigned n_directed = 0;
  int unsigned phase1_at = 0;
  int unsigned phase2_at = 0;

  interval_set_membership_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic [VALUE_BITS-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VALUE_BITS-1:0];
  endfunction

  function automatic int unsigned idle_pct(int unsigned n, bit sender);
    if (n < phase1_at) return sender ? 32 : 83;
    if (n < phase2_at) return sender ? 83 : 32;
    return 0;
  endfunction

  // Table model: updates state for one accepted beat and returns its result.
  function automatic ismc_out_t answer_item(ismc_in_t it);
    ismc_out_t r;
    r = '0;
    r.status = ST_OK;
    if (it.kind == KIND_ADD) begin
      if (n_held >= MAX_INTERVALS) begin
        r.status = ST_FULL;
      end else if (it.interval_start > it.interval_end) begin
        r.status = ST_INVERTED;
      end else begin
        tab_lo[n_held] = it.interval_start;
        tab_hi[n_held] = it.interval_end;
        n_held++;
      end
    end else begin
      for (int i = 0; i < n_held; i++) begin
        if (it.query_value >= tab_lo[i] && it.query_value <= tab_hi[i]) r.hit = 1'b1;
      end
      if (r.hit && hit_tally != {HIT_W{1'b1}}) hit_tally++;
    end
    r.hit_count = hit_tally;
    r.stored_count = n_held[STORED_W-1:0];
    return r;
  endfunction

  task automatic queue_add(logic [VALUE_BITS-1:0] s, logic [VALUE_BITS-1:0] e);
    ismc_in_t it;
    it.kind = KIND_ADD;
    it.interval_start = s;
    it.interval_end = e;
    it.query_value = rand48();
    feed.push_back(it);
    if (s <= e && gen_lo.size() < MAX_INTERVALS) begin
      gen_lo.push_back(s);
      gen_hi.push_back(e);
    end
  endtask

  task automatic queue_query(logic [VALUE_BITS-1:0] v);
    ismc_in_t it;
    it.kind = KIND_QUERY;
    it.interval_start = rand48();
    it.interval_end = rand48();
    it.query_value = v;
    feed.push_back(it);
  endtask

  always @(posedge clk) begin : drive
    bit took;
    int unsigned taken;
    took = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        pending_answers.push_back(answer_item(in_data));
        n_accepted <= n_accepted + 1;
      end
      taken = n_accepted + took;
      if (!in_valid || took) begin
        // at a phase boundary, hold off until the block has drained
        if (feed.size() == 0 || $urandom_range(99) < idle_pct(issued, 1'b1) ||
            ((issued == n_directed || issued == phase1_at || issued == phase2_at) &&
             taken != n_answered)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= feed.pop_front();
          issued <= issued + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct(issued, 1'b0));
  end

  always @(posedge clk) begin : check
    ismc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_answered <= n_answered + 1;
      if (pending_answers.size() == 0) begin
        $error("result beat with no pending answer");
        n_errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_errors++;
        end
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
          n_errors++;
        end
        if (out_data.hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d, got %0d", want.hit_count, out_data.hit_count);
          n_errors++;
        end
        if (out_data.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d, got %0d", want.stored_count,
                 out_data.stored_count);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VALUE_BITS-1:0] lo_v, hi_v, a, b, val;
    logic [63:0] span, top, r64;
    int unsigned pick, total;

    // empty table, extremes, inverted and one-value intervals
    queue_query('0);
    queue_query(MAXV);
    queue_add('0, '0);
    queue_add(MAXV, MAXV);
    queue_add(MAXV, '0);
    queue_add(48'd5, 48'd4);
    queue_query(48'd5);
    queue_query(48'd4);
    queue_query('0);
    queue_query(MAXV);
    queue_query(48'd1);
    // overlapping and nested
    queue_add(48'd100, 48'd200);
    queue_add(48'd150, 48'd300);
    queue_add(48'd120, 48'd130);
    queue_add(48'd301, 48'd301);
    queue_query(48'd99);
    queue_query(48'd100);
    queue_query(48'd125);
    queue_query(48'd150);
    queue_query(48'd300);
    queue_query(48'd301);
    queue_query(48'd302);
    queue_add(48'h8000_0000_0000, 48'h8000_0000_0FFF);
    queue_query(48'h8000_0000_0FFF);
    queue_query(48'h7FFF_FFFF_FFFF);
    n_directed = feed.size();

    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(99) < (gen_lo.size() < MAX_INTERVALS ? 35 : 10)) begin
        if ($urandom_range(9) == 0) begin
          a = rand48();
          b = rand48();
          if (a == b) b = a ^ 48'd1;
          if (a > b) queue_add(a, b);
          else queue_add(b, a);
        end else begin
          lo_v = rand48() >> $urandom_range(VALUE_BITS - 1);
          case ($urandom_range(2))
            0: span = 64'd0;
            1: span = $urandom_range(1000);
            default: span = {16'b0, rand48() >> $urandom_range(VALUE_BITS - 1, 8)};
          endcase
          top = {16'b0, lo_v} + span;
          hi_v = (top > {16'b0, MAXV}) ? MAXV : top[VALUE_BITS-1:0];
          queue_add(lo_v, hi_v);
        end
      end else begin
        if (gen_lo.size() == 0) begin
          val = rand48();
        end else begin
          pick = $urandom_range(gen_lo.size() - 1);
          lo_v = gen_lo[pick];
          hi_v = gen_hi[pick];
          case ($urandom_range(7))
            0, 1, 2: begin
              span = {16'b0, hi_v} - {16'b0, lo_v} + 64'd1;
              r64 = {$urandom, $urandom};
              top = {16'b0, lo_v} + (r64 % span);
              val = top[VALUE_BITS-1:0];
            end
            3: val = lo_v;
            4: val = hi_v;
            5: val = lo_v - 1'b1;
            6: val = hi_v + 1'b1;
            default: val = rand48();
          endcase
        end
        queue_query(val);
      end
    end

    total = feed.size();
    phase1_at = total / 3;
    phase2_at = 2 * total / 3;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (feed.size() != 0 || in_valid || pending_answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
